[hw/rtl/rclfr_pkg.sv]
// ----------------------------------------------------------------------------
// rclfr_pkg
// Shared types, constants and the crc-8 step for the rc link frame receiver.
// ----------------------------------------------------------------------------
package rclfr_pkg;

  localparam int unsigned MAX_FRAME_BYTES_DEFAULT = 64;

  localparam logic [7:0] SYNC_VALUE_RESET = 8'hC8;
  localparam logic [5:0] MAX_LEN_RESET    = 6'd62;
  localparam logic [7:0] CRC_POLY         = 8'hD5;
  localparam logic [7:0] TYPE_RC_CHANNELS = 8'h16;
  localparam logic [7:0] MIN_LEN          = 8'd2;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_VALUE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN    = 2'd1;

  typedef struct packed {
    logic [7:0] sync_value;
    logic [5:0] max_len;
  } rclfr_cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] out_byte;
    logic [5:0] byte_index;
    logic       last;
    logic       crc_ok;
    logic       is_rc_channels;
  } rclfr_result_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[hw/rtl/rc_link_frame_receiver.sv]
// ----------------------------------------------------------------------------
// rc_link_frame_receiver
// Serial rc link frame receiver with sync hunt, length check and crc-8 check.
// ----------------------------------------------------------------------------
// path: a body byte is held in the s1 input register, then in the output register out_q
// throughput: one byte per cycle while the output is not stalled; the crc-8 step is combinational
// sync and length bytes produce no output transaction
// reset: parser hunts for sync, registers return to 0xC8 and 62, pipeline empty
module rc_link_frame_receiver import rclfr_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]           cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           rx_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           out_byte_o,
  output logic [5:0]           byte_index_o,
  output logic                 last_o,
  output logic                 crc_ok_o,
  output logic                 is_rc_channels_o
);

  rclfr_cfg_t    cfg;
  rclfr_result_t res;

  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       out_valid_q, out_valid_d;
  rclfr_result_t out_q;
  logic       out_free;
  logic       step;

  rclfr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  rclfr_parser #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (step),
    .byte_i (s1_byte_q),
    .res_o  (res)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign step       = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_ready_o) begin
      s1_valid_d = in_valid_i;
    end
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = step && res.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_byte_q <= rx_byte_i;
    end
    if (step && res.valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_byte_o       = out_q.out_byte;
  assign byte_index_o     = out_q.byte_index;
  assign last_o           = out_q.last;
  assign crc_ok_o         = out_q.crc_ok;
  assign is_rc_channels_o = out_q.is_rc_channels;

endmodule

[hw/rtl/rclfr_cfg_regs.sv]
// ----------------------------------------------------------------------------
// rclfr_cfg_regs
// Configuration registers: sync byte value and largest accepted length.
// ----------------------------------------------------------------------------
module rclfr_cfg_regs import rclfr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]           cfg_data_i,
  output rclfr_cfg_t           cfg_o
);

  rclfr_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SYNC_VALUE: cfg_d.sync_value = cfg_data_i;
        REG_MAX_LEN:    cfg_d.max_len    = cfg_data_i[5:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_value <= SYNC_VALUE_RESET;
      cfg_q.max_len    <= MAX_LEN_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hw/rtl/rclfr_parser.sv]
// ----------------------------------------------------------------------------
// rclfr_parser
// Frame state machine: sync hunt, length check, body indexing and crc-8.
// ----------------------------------------------------------------------------
module rclfr_parser import rclfr_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEFAULT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rclfr_cfg_t    cfg_i,
  input  logic          step_i,
  input  logic [7:0]    byte_i,
  output rclfr_result_t res_o
);

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;

  localparam int unsigned LenCap = MAX_FRAME_BYTES - 2;
  localparam logic [7:0] LenCapB = LenCap[7:0];

  logic [1:0] phase_q, phase_d;
  logic [5:0] len_q, len_d;
  logic [5:0] pos_q, pos_d;
  logic [7:0] crc_q, crc_d;
  logic [7:0] type_q, type_d;

  logic [7:0] limit;
  logic [6:0] pos_inc;
  logic       is_last;

  assign limit   = ({2'b00, cfg_i.max_len} <= LenCapB) ? {2'b00, cfg_i.max_len} : LenCapB;
  assign pos_inc = {1'b0, pos_q} + 7'd1;
  assign is_last = pos_inc >= {1'b0, len_q};

  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    pos_d   = pos_q;
    crc_d   = crc_q;
    type_d  = type_q;
    res_o   = '0;
    if (step_i) begin
      unique case (phase_q)
        PH_HUNT: begin
          if (byte_i == cfg_i.sync_value) begin
            phase_d = PH_LEN;
          end
        end
        PH_LEN: begin
          if (byte_i < MIN_LEN || byte_i > limit) begin
            phase_d = PH_HUNT;
          end else begin
            len_d   = byte_i[5:0];
            pos_d   = '0;
            crc_d   = '0;
            type_d  = '0;
            phase_d = PH_BODY;
          end
        end
        PH_BODY: begin
          res_o.valid      = 1'b1;
          res_o.out_byte   = byte_i;
          res_o.byte_index = pos_q;
          res_o.last       = is_last;
          if (is_last) begin
            res_o.crc_ok         = (crc_q == byte_i);
            res_o.is_rc_channels = (type_q == TYPE_RC_CHANNELS);
            phase_d = PH_HUNT;
            pos_d   = '0;
          end else begin
            if (pos_q == '0) begin
              type_d = byte_i;
            end
            crc_d = crc8_step(crc_q, byte_i);
            pos_d = pos_inc[5:0];
          end
        end
        default: phase_d = PH_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      len_q   <= '0;
      pos_q   <= '0;
      crc_q   <= '0;
      type_q  <= '0;
    end else begin
      phase_q <= phase_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
      crc_q   <= crc_d;
      type_q  <= type_d;
    end
  end

endmodule
